// ===== rtl/rtp_pkg.sv =====
// ----------------------------------------------------------------------------
// rtp_pkg: shared types and constants
// Widths, register indexes and the item type passed from front to back.
// ----------------------------------------------------------------------------
package rtp_pkg;

  // field widths
  localparam int LAT_W     = 18;
  localparam int LON_W     = 19;
  localparam int OP_W      = 20;   // lateral/longitudinal as signed operands
  localparam int COEF_W    = 32;
  localparam int PROD_W    = 52;   // coefficient times operand
  localparam int SUM_W     = 54;   // affine sums u, v, z
  localparam int FXM_W     = 42;   // fx times 1000
  localparam int SQ_W      = 40;   // lat^2 + long^2
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  localparam int PIXEL_BITS = 16;
  localparam int METRE_W    = 16;
  localparam int RANGE_W    = 19;

  // divider: quotient bits cover the widest pixel and the metre width
  localparam int DIV_W    = SUM_W;
  localparam int DIV_QW   = 20;
  localparam int BACK_LAT = DIV_QW + 1;

  // square root: one result bit per stage, same depth as the divider
  localparam int SQRT_STEPS = BACK_LAT;
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int SQ_PAD_W   = 2 * SQRT_STEPS;
  localparam int REM_W      = ROOT_W + 3;

  localparam logic signed [10:0]  METRE_MM  = 11'sd1000;
  localparam logic [METRE_W-1:0]  METRE_MAX = {METRE_W{1'b1}};
  localparam logic [RANGE_W-1:0]  RANGE_MAX = {RANGE_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_U_COEF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_V_COEF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_COEF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UV_OFS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_FX   = 3'd4;

  typedef struct packed {
    logic signed [COEF_W-1:0] u_l;
    logic signed [COEF_W-1:0] u_g;
    logic signed [COEF_W-1:0] v_l;
    logic signed [COEF_W-1:0] v_g;
    logic signed [COEF_W-1:0] z_l;
    logic signed [COEF_W-1:0] z_g;
    logic signed [COEF_W-1:0] u_o;
    logic signed [COEF_W-1:0] v_o;
    logic signed [COEF_W-1:0] z_o;
    logic signed [COEF_W-1:0] fx;
  } cfg_t;

  typedef struct packed {
    logic [DIV_W-1:0] u_mag;
    logic [DIV_W-1:0] v_mag;
    logic [DIV_W-1:0] m_mag;
    logic [DIV_W-1:0] z_mag;
    logic             u_neg;
    logic             v_neg;
    logic             behind;
    logic [SQ_W-1:0]  sq;
  } item_t;

  typedef struct packed {
    logic behind;
    logic u_neg;
    logic v_neg;
  } side_t;

endpackage

// ===== rtl/rtp_front.sv =====
// ----------------------------------------------------------------------------
// rtp_front: product, sum and classify stages
// Three stages: products, affine sums, magnitudes and depth sign check.
// ----------------------------------------------------------------------------
module rtp_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [rtp_pkg::LAT_W-1:0]     lateral_mm,
  input  logic        [rtp_pkg::LON_W-1:0]     longitudinal_mm,
  input  rtp_pkg::cfg_t                        cfg,
  input  logic                                 q_ready,
  output logic                                 busy,
  output logic                                 push,
  output rtp_pkg::item_t                       item
);

  logic signed [rtp_pkg::OP_W-1:0]   lat_s;
  logic signed [rtp_pkg::OP_W-1:0]   lon_s;

  // stage 1
  logic                                s1_valid;
  logic signed [rtp_pkg::PROD_W-1:0]   p_ul, p_ug, p_vl, p_vg, p_zl, p_zg;
  logic signed [rtp_pkg::COEF_W-1:0]   o_u, o_v, o_z;
  logic signed [rtp_pkg::FXM_W-1:0]    fxm1;
  logic signed [2*rtp_pkg::LAT_W-1:0]  lat2;
  logic        [2*rtp_pkg::LON_W-1:0]  lon2;

  // stage 2
  logic                                s2_valid;
  logic signed [rtp_pkg::SUM_W-1:0]    u_sum, v_sum, z_sum;
  logic signed [rtp_pkg::FXM_W-1:0]    fxm2;
  logic        [rtp_pkg::SQ_W-1:0]     sq2;

  logic        [rtp_pkg::SUM_W-1:0]    u_abs, v_abs;
  logic        [rtp_pkg::FXM_W-1:0]    fxm_abs;

  assign busy  = !q_ready;
  assign lat_s = rtp_pkg::OP_W'(lateral_mm);
  assign lon_s = $signed({1'b0, longitudinal_mm});

  // valid pipeline, held while the queue cannot take an item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      push     <= 1'b0;
    end else if (q_ready) begin
      s1_valid <= start;
      s2_valid <= s1_valid;
      push     <= s2_valid;
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (q_ready) begin
      p_ul <= cfg.u_l * lat_s;
      p_ug <= cfg.u_g * lon_s;
      p_vl <= cfg.v_l * lat_s;
      p_vg <= cfg.v_g * lon_s;
      p_zl <= cfg.z_l * lat_s;
      p_zg <= cfg.z_g * lon_s;
      o_u  <= cfg.u_o;
      o_v  <= cfg.v_o;
      o_z  <= cfg.z_o;
      fxm1 <= cfg.fx * rtp_pkg::METRE_MM;
      lat2 <= lateral_mm * lateral_mm;
      lon2 <= longitudinal_mm * longitudinal_mm;
    end
  end

  // stage 2: affine sums and squared range
  always_ff @(posedge clk) begin
    if (q_ready) begin
      u_sum <= p_ul + p_ug + o_u;
      v_sum <= p_vl + p_vg + o_v;
      z_sum <= p_zl + p_zg + o_z;
      fxm2  <= fxm1;
      sq2   <= rtp_pkg::SQ_W'($unsigned(lat2)) + rtp_pkg::SQ_W'(lon2);
    end
  end

  // magnitudes for the unsigned divider
  always_comb begin
    u_abs   = $unsigned(u_sum[rtp_pkg::SUM_W-1] ? -u_sum : u_sum);
    v_abs   = $unsigned(v_sum[rtp_pkg::SUM_W-1] ? -v_sum : v_sum);
    fxm_abs = $unsigned(fxm2[rtp_pkg::FXM_W-1] ? -fxm2 : fxm2);
  end

  // stage 3: classify and hand to the queue
  always_ff @(posedge clk) begin
    if (q_ready) begin
      item.u_mag  <= u_abs;
      item.v_mag  <= v_abs;
      item.m_mag  <= rtp_pkg::DIV_W'(fxm_abs);
      item.z_mag  <= $unsigned(z_sum);
      item.u_neg  <= u_sum[rtp_pkg::SUM_W-1];
      item.v_neg  <= v_sum[rtp_pkg::SUM_W-1];
      item.behind <= z_sum[rtp_pkg::SUM_W-1] || (z_sum == '0);
      item.sq     <= sq2;
    end
  end

endmodule

// ===== rtl/rtp_queue.sv =====
// ----------------------------------------------------------------------------
// rtp_queue: two-entry item queue
// Decouples the front stages from the back; the back drains it every cycle.
// ----------------------------------------------------------------------------
module rtp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  rtp_pkg::item_t  in_item,
  output logic            in_ready,
  output logic            out_valid,
  output rtp_pkg::item_t  out_item
);

  rtp_pkg::item_t mem [0:1];
  logic           wp;
  logic           rp;
  logic [1:0]     cnt;
  logic           wr_en;
  logic           rd_en;

  assign out_valid = (cnt != 2'd0);
  assign rd_en     = out_valid;
  assign in_ready  = (cnt != 2'd2) || rd_en;
  assign wr_en     = in_valid && in_ready;
  assign out_item  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp] <= in_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr_en) wp <= !wp;
      if (rd_en) rp <= !rp;
      cnt <= cnt + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

// ===== rtl/rtp_div.sv =====
// ----------------------------------------------------------------------------
// rtp_div: pipelined unsigned divider
// Overflow check, then one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
module rtp_div (
  input  logic                        clk,
  input  logic [rtp_pkg::DIV_W-1:0]   num,
  input  logic [rtp_pkg::DIV_W-1:0]   den,
  output logic [rtp_pkg::DIV_QW-1:0]  quo,
  output logic                        ovf
);

  localparam int QW = rtp_pkg::DIV_QW;
  localparam int DW = rtp_pkg::DIV_W;
  localparam int CW = DW + QW;

  logic [DW-1:0] r_s   [0:QW];
  logic [DW-1:0] d_s   [0:QW];
  logic [QW-1:0] q_s   [0:QW];
  logic          ovf_s [0:QW];

  // quotient will not fit in QW bits
  always_ff @(posedge clk) begin
    r_s[0]   <= num;
    d_s[0]   <= den;
    q_s[0]   <= '0;
    ovf_s[0] <= ({{QW{1'b0}}, num} >= {den, {QW{1'b0}}});
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int B = QW - 1 - k;
    logic [CW:0]   diff;
    logic [QW-1:0] q_bit;

    always_comb begin
      diff  = {1'b0, {QW{1'b0}}, r_s[k]} - ({1'b0, {QW{1'b0}}, d_s[k]} << B);
      q_bit = '0;
      q_bit[B] = !diff[CW];
    end

    always_ff @(posedge clk) begin
      r_s[k+1]   <= diff[CW] ? r_s[k] : diff[DW-1:0];
      d_s[k+1]   <= d_s[k];
      q_s[k+1]   <= q_s[k] | q_bit;
      ovf_s[k+1] <= ovf_s[k];
    end
  end

  assign quo = q_s[QW];
  assign ovf = ovf_s[QW];

endmodule

// ===== rtl/rtp_sqrt.sv =====
// ----------------------------------------------------------------------------
// rtp_sqrt: pipelined integer square root
// Digit-by-digit floor root, one root bit per stage.
// ----------------------------------------------------------------------------
module rtp_sqrt (
  input  logic                         clk,
  input  logic [rtp_pkg::SQ_W-1:0]     n,
  output logic [rtp_pkg::ROOT_W-1:0]   root
);

  localparam int S  = rtp_pkg::SQRT_STEPS;
  localparam int NW = rtp_pkg::SQ_PAD_W;
  localparam int RW = rtp_pkg::REM_W;
  localparam int TW = rtp_pkg::ROOT_W;

  logic [NW-1:0] n_s    [0:S-1];
  logic [RW-1:0] rem_s  [0:S-1];
  logic [TW-1:0] root_s [0:S-1];

  for (genvar k = 0; k < S; k++) begin : g_step
    localparam int J = S - 1 - k;
    logic [NW-1:0] n_in;
    logic [RW-1:0] rem_in;
    logic [TW-1:0] root_in;
    logic [RW-1:0] cur;
    logic [RW-1:0] trial;
    logic [RW:0]   diff;

    if (k == 0) begin : g_first
      assign n_in    = NW'(n);
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign n_in    = n_s[k-1];
      assign rem_in  = rem_s[k-1];
      assign root_in = root_s[k-1];
    end

    // bring down two bits and try root*4+1
    always_comb begin
      cur   = {rem_in[RW-3:0], n_in[2*J+1 -: 2]};
      trial = {1'b0, root_in, 2'b01};
      diff  = {1'b0, cur} - {1'b0, trial};
    end

    always_ff @(posedge clk) begin
      n_s[k]    <= n_in;
      rem_s[k]  <= diff[RW] ? cur : diff[RW-1:0];
      root_s[k] <= {root_in[TW-2:0], !diff[RW]};
    end
  end

  assign root = root_s[S-1];

endmodule

// ===== rtl/rtp_back.sv =====
// ----------------------------------------------------------------------------
// rtp_back: division, square root and saturation
// Three divider lanes and a root pipeline in lockstep, then output register.
// ----------------------------------------------------------------------------
module rtp_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  rtp_pkg::item_t                         in_item,
  output logic                                   done,
  output logic signed [rtp_pkg::PIXEL_BITS-1:0]  pixel_x,
  output logic signed [rtp_pkg::PIXEL_BITS-1:0]  pixel_y,
  output logic        [rtp_pkg::METRE_W-1:0]     one_metre_pixels,
  output logic        [rtp_pkg::RANGE_W-1:0]     range_mm,
  output logic                                   behind_camera
);

  localparam int LAT = rtp_pkg::BACK_LAT;
  localparam int P   = rtp_pkg::PIXEL_BITS;
  localparam int QW  = rtp_pkg::DIV_QW;
  localparam logic [QW-1:0] PIX_POS_MAX = QW'((1 << (P - 1)) - 1);
  localparam logic [QW-1:0] PIX_NEG_MAG = QW'(1 << (P - 1));

  logic [LAT-1:0]               vld_s;
  rtp_pkg::side_t               side_s [0:LAT-1];
  logic [QW-1:0]                qu, qv, qm;
  logic                         ou, ov, om;
  logic [rtp_pkg::ROOT_W-1:0]   root;
  rtp_pkg::side_t               side_out;

  // truncated quotient magnitude and sign to a saturated pixel
  function automatic logic [P-1:0] sat_pix(input logic [QW-1:0] q, input logic o,
                                           input logic neg);
    logic [QW-1:0] nq;
    nq = QW'(0) - q;
    if (neg) begin
      sat_pix = (o || q > PIX_NEG_MAG) ? PIX_NEG_MAG[P-1:0] : nq[P-1:0];
    end else begin
      sat_pix = (o || q > PIX_POS_MAX) ? PIX_POS_MAX[P-1:0] : q[P-1:0];
    end
  endfunction

  rtp_div u_div_u (.clk(clk), .num(in_item.u_mag), .den(in_item.z_mag), .quo(qu), .ovf(ou));
  rtp_div u_div_v (.clk(clk), .num(in_item.v_mag), .den(in_item.z_mag), .quo(qv), .ovf(ov));
  rtp_div u_div_m (.clk(clk), .num(in_item.m_mag), .den(in_item.z_mag), .quo(qm), .ovf(om));

  rtp_sqrt u_sqrt (.clk(clk), .n(in_item.sq), .root(root));

  // sideband delay matching the arithmetic pipelines
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s <= '0;
    end else begin
      vld_s <= {vld_s[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    side_s[0] <= '{behind: in_item.behind, u_neg: in_item.u_neg, v_neg: in_item.v_neg};
    for (int k = 1; k < LAT; k++) begin
      side_s[k] <= side_s[k-1];
    end
  end

  assign side_out = side_s[LAT-1];

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_s[LAT-1];
    end
  end

  // saturate and register the result item
  always_ff @(posedge clk) begin
    behind_camera <= side_out.behind;
    range_mm      <= (root > rtp_pkg::ROOT_W'(rtp_pkg::RANGE_MAX)) ? rtp_pkg::RANGE_MAX
                                                                  : root[rtp_pkg::RANGE_W-1:0];
    if (side_out.behind) begin
      pixel_x          <= '0;
      pixel_y          <= '0;
      one_metre_pixels <= '0;
    end else begin
      pixel_x          <= sat_pix(qu, ou, side_out.u_neg);
      pixel_y          <= sat_pix(qv, ov, side_out.v_neg);
      one_metre_pixels <= (om || qm > QW'(rtp_pkg::METRE_MAX)) ? rtp_pkg::METRE_MAX
                                                               : qm[rtp_pkg::METRE_W-1:0];
    end
  end

endmodule

// ===== rtl/radar_target_pixel_projection.sv =====
// ----------------------------------------------------------------------------
// radar_target_pixel_projection: radar target to camera pixel
// Projects one radar target per item through a pinhole camera model.
// ----------------------------------------------------------------------------
// Usage:
//   Load the five 64-bit weight registers through cfg_valid/cfg_ready with
//   cfg_index and cfg_data while no item is in flight; cfg_ready is always
//   high and indexes past the last register are ignored.
//   Drive start with lateral_mm and longitudinal_mm; the item is taken on an
//   edge where start is high and busy is low. One item per cycle sustained while busy stays low.
//   done pulses for one cycle for each accepted item, with pixel_x, pixel_y,
//   one_metre_pixels, range_mm and behind_camera.
//   Results pass through the 21-stage divider and square root pipelines,
//   an overflow check then one quotient bit per stage, or one root bit per
//   stage, behind three front stages and the item queue.
//   The receiver cannot hold results off; the back end drains the queue
//   every cycle, so busy stays low in normal use.
//   Reset clears all weight registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module radar_target_pixel_projection (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [rtp_pkg::LAT_W-1:0]       lateral_mm,
  input  logic        [rtp_pkg::LON_W-1:0]       longitudinal_mm,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [rtp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [rtp_pkg::CFG_W-1:0]       cfg_data,
  output logic                                   done,
  output logic signed [rtp_pkg::PIXEL_BITS-1:0]  pixel_x,
  output logic signed [rtp_pkg::PIXEL_BITS-1:0]  pixel_y,
  output logic        [rtp_pkg::METRE_W-1:0]     one_metre_pixels,
  output logic        [rtp_pkg::RANGE_W-1:0]     range_mm,
  output logic                                   behind_camera
);

  logic [rtp_pkg::CFG_W-1:0] cfg_u, cfg_v, cfg_z, cfg_uvo, cfg_zof;
  rtp_pkg::cfg_t             cfg;
  logic                      q_ready;
  logic                      push;
  rtp_pkg::item_t            f_item;
  logic                      b_valid;
  rtp_pkg::item_t            b_item;

  assign cfg_ready = 1'b1;

  // weight registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_u   <= '0;
      cfg_v   <= '0;
      cfg_z   <= '0;
      cfg_uvo <= '0;
      cfg_zof <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rtp_pkg::CFG_U_COEF: cfg_u   <= cfg_data;
        rtp_pkg::CFG_V_COEF: cfg_v   <= cfg_data;
        rtp_pkg::CFG_Z_COEF: cfg_z   <= cfg_data;
        rtp_pkg::CFG_UV_OFS: cfg_uvo <= cfg_data;
        rtp_pkg::CFG_Z_FX:   cfg_zof <= cfg_data;
        default: ;
      endcase
    end
  end

  // split into signed words, high word first
  always_comb begin
    cfg.u_l = $signed(cfg_u[63:32]);
    cfg.u_g = $signed(cfg_u[31:0]);
    cfg.v_l = $signed(cfg_v[63:32]);
    cfg.v_g = $signed(cfg_v[31:0]);
    cfg.z_l = $signed(cfg_z[63:32]);
    cfg.z_g = $signed(cfg_z[31:0]);
    cfg.u_o = $signed(cfg_uvo[63:32]);
    cfg.v_o = $signed(cfg_uvo[31:0]);
    cfg.z_o = $signed(cfg_zof[63:32]);
    cfg.fx  = $signed(cfg_zof[31:0]);
  end

  rtp_front u_front (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .lateral_mm      (lateral_mm),
    .longitudinal_mm (longitudinal_mm),
    .cfg             (cfg),
    .q_ready         (q_ready),
    .busy            (busy),
    .push            (push),
    .item            (f_item)
  );

  rtp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push),
    .in_item   (f_item),
    .in_ready  (q_ready),
    .out_valid (b_valid),
    .out_item  (b_item)
  );

  rtp_back u_back (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (b_valid),
    .in_item          (b_item),
    .done             (done),
    .pixel_x          (pixel_x),
    .pixel_y          (pixel_y),
    .one_metre_pixels (one_metre_pixels),
    .range_mm         (range_mm),
    .behind_camera    (behind_camera)
  );

endmodule

// ===== verif/tb_radar_target_pixel_projection.sv =====
// ----------------------------------------------------------------------------
// tb_radar_target_pixel_projection: self-checking bench for the projector
// Loads weight sets, drives directed and random targets with random gaps,
// predicts each projection in the bench and compares every result field.
// ----------------------------------------------------------------------------
module tb_radar_target_pixel_projection;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 2000;
  localparam int DRAIN    = 40;

  typedef struct {
    logic signed [rtp_pkg::LAT_W-1:0] lat;
    logic        [rtp_pkg::LON_W-1:0] lon;
  } target_t;

  typedef struct {
    logic signed [rtp_pkg::PIXEL_BITS-1:0] px;
    logic signed [rtp_pkg::PIXEL_BITS-1:0] py;
    logic        [rtp_pkg::METRE_W-1:0]    metre;
    logic        [rtp_pkg::RANGE_W-1:0]    rng;
    logic                                  behind;
  } proj_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [rtp_pkg::LAT_W-1:0] lateral_mm = '0;
  logic [rtp_pkg::LON_W-1:0] longitudinal_mm = '0;
  logic cfg_valid = 1'b0;
  logic [rtp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rtp_pkg::CFG_W-1:0] cfg_data = '0;
  logic busy, cfg_ready, done, behind_camera;
  logic signed [rtp_pkg::PIXEL_BITS-1:0] pixel_x, pixel_y;
  logic [rtp_pkg::METRE_W-1:0] one_metre_pixels;
  logic [rtp_pkg::RANGE_W-1:0] range_mm;

  radar_target_pixel_projection dut (.*);

  always #5 clk = ~clk;

  // bench copy of the weight registers
  logic [rtp_pkg::CFG_W-1:0] wt [5];

  target_t pending_targets[$];
  proj_t   expected_proj[$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  bit      quiet = 1'b0;

  // sampled busy so the driver drops only items the block took
  logic busy_q = 1'b0;

  function automatic longint hi32(logic [rtp_pkg::CFG_W-1:0] r);
    return longint'($signed(r[63:32]));
  endfunction

  function automatic longint lo32(logic [rtp_pkg::CFG_W-1:0] r);
    return longint'($signed(r[31:0]));
  endfunction

  function automatic longint isqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [rtp_pkg::PIXEL_BITS-1:0] clamp_pixel(longint q);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[rtp_pkg::PIXEL_BITS-1:0];
  endfunction

  function automatic proj_t project(target_t t);
    proj_t p;
    longint lat, lon, u, v, z, fx, m;
    longint unsigned r;
    lat = longint'(t.lat);
    lon = longint'({1'b0, t.lon});
    u = hi32(wt[0]) * lat + lo32(wt[0]) * lon + hi32(wt[3]);
    v = hi32(wt[1]) * lat + lo32(wt[1]) * lon + lo32(wt[3]);
    z = hi32(wt[2]) * lat + lo32(wt[2]) * lon + hi32(wt[4]);
    fx = lo32(wt[4]);
    r = isqrt(lat * lat + lon * lon);
    if (r > 524287) r = 524287;
    p.rng = r[rtp_pkg::RANGE_W-1:0];
    if (z <= 0) begin
      p.px = '0; p.py = '0; p.metre = '0; p.behind = 1'b1;
    end else begin
      m = (fx * 1000) / z;
      if (m < 0) m = -m;
      if (m > 65535) m = 65535;
      p.metre = m[rtp_pkg::METRE_W-1:0];
      p.px = clamp_pixel(u / z);
      p.py = clamp_pixel(v / z);
      p.behind = 1'b0;
    end
    return p;
  endfunction

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  // driver: start held while items wait, gaps at random
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !busy_q) begin
        pending_targets.delete(0);
      end
      if (pending_targets.size() > 0 && (quiet || $urandom_range(0, 99) >= 36)) begin
        start <= 1'b1;
        lateral_mm <= pending_targets[0].lat;
        longitudinal_mm <= pending_targets[0].lon;
      end else begin
        start <= 1'b0;
        lateral_mm <= rtp_pkg::LAT_W'($urandom);
        longitudinal_mm <= rtp_pkg::LON_W'($urandom);
      end
    end
  end

  // predict each item at the edge that takes it
  always @(posedge clk) begin
    busy_q <= busy;
    if (!rst && start && !busy) begin
      expected_proj = {expected_proj,
                       project('{lat: lateral_mm, lon: longitudinal_mm})};
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    proj_t e;
    if (!rst && done) begin
      if (expected_proj.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        e = expected_proj[0];
        expected_proj.delete(0);
        if (pixel_x !== e.px || pixel_y !== e.py || one_metre_pixels !== e.metre ||
            range_mm !== e.rng || behind_camera !== e.behind) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp x=%0d y=%0d m=%0d r=%0d b=%0b got x=%0d y=%0d m=%0d r=%0d b=%0b",
                     e.px, e.py, e.metre, e.rng, e.behind, pixel_x, pixel_y,
                     one_metre_pixels, range_mm, behind_camera);
        end
      end
    end
  end

  // watchdog on cycles with no accepted item, result or register write
  always @(posedge clk) begin
    if ((start && !busy) || done || cfg_valid || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("tb_radar_target_pixel_projection: FAIL");
      $finish;
    end
  end

  task automatic write_reg(int idx, logic [rtp_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx[rtp_pkg::CFG_IDX_W-1:0];
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    wt[idx] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (pending_targets.size() > 0 || expected_proj.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic add_target(int lat, int lon);
    target_t t;
    t.lat = lat[rtp_pkg::LAT_W-1:0];
    t.lon = lon[rtp_pkg::LON_W-1:0];
    pending_targets = {pending_targets, t};
  endtask

  initial begin
    logic [rtp_pkg::CFG_W-1:0] w;
    for (int i = 0; i < 5; i++) wt[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all-zero weights: everything behind the camera
    add_target(-131072, 0);
    add_target(131071, 524287);
    settle();

    // plausible camera: u = 800*lat + 640*long, v = 360*long, z = long
    write_reg(rtp_pkg::CFG_U_COEF, {32'd800, 32'd640});
    write_reg(rtp_pkg::CFG_V_COEF, {32'd0, 32'd360});
    write_reg(rtp_pkg::CFG_Z_COEF, {32'd0, 32'd1});
    write_reg(rtp_pkg::CFG_UV_OFS, {32'd0, 32'd0});
    write_reg(rtp_pkg::CFG_Z_FX, {32'd0, 32'd800});
    add_target(0, 0);
    add_target(0, 1);
    add_target(-131072, 1);
    add_target(131071, 1);
    add_target(-131072, 327679);
    add_target(131071, 524287);
    add_target(1000, 20000);
    add_target(-5000, 3);
    add_target(-1, 524287);
    settle();

    // negative focal, large offsets, saturating weights
    write_reg(rtp_pkg::CFG_Z_FX, {32'h7FFF_FFFF, 32'h8000_0000});
    write_reg(rtp_pkg::CFG_UV_OFS, {32'h8000_0000, 32'h7FFF_FFFF});
    add_target(0, 0);
    add_target(-131072, 524287);
    add_target(131071, 0);
    settle();
    write_reg(rtp_pkg::CFG_Z_COEF, {32'h8000_0000, 32'h7FFF_FFFF});
    add_target(1, 1);
    add_target(-131072, 524287);
    settle();

    // random phases with random weight sets
    for (int ph = 0; ph < 9; ph++) begin
      for (int r = 0; r < 5; r++) begin
        w = {rnd_word(), rnd_word()};
        if (r == rtp_pkg::CFG_Z_COEF && $urandom_range(0, 1)) w[31:0] = $urandom_range(1, 4096);
        write_reg(r, w);
      end
      quiet = (ph == 4);
      for (int k = 0; k < 50; k++) begin
        case ($urandom_range(0, 4))
          0: add_target($urandom_range(0, 1) ? -131072 : 131071, $urandom_range(0, 524287));
          1: add_target($signed($urandom_range(0, 2000)) - 1000, $urandom_range(0, 3000));
          default: add_target($urandom, $urandom_range(0, 524287));
        endcase
      end
      settle();
    end
    quiet = 1'b0;

    if (mismatches == 0) begin
      $display("tb_radar_target_pixel_projection: PASS");
    end else begin
      $display("tb_radar_target_pixel_projection: FAIL");
    end
    $finish;
  end
endmodule
